[hw/rtl/tsre_pkg.sv]
package tsre_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int OFFSET_BITS = 24;
    localparam int ADDR_BITS   = 24;
    localparam int DATA_BITS   = 32;
    localparam int PIXEL_BITS  = 8;
    localparam int LEN_BITS    = 16;
    localparam int COL_BITS    = $clog2(MAX_WIDTH + 1);
    localparam int CFG_BITS    = 13;
    localparam int CFG_IDX_BITS = 2;

    // writes one pixel can cause: skip run header, opaque byte, closing run header, newline header
    localparam int MAX_WRITES  = 4;
    localparam int SLOT_BITS   = $clog2(MAX_WRITES);
    localparam int WCNT_BITS   = $clog2(MAX_WRITES + 1);

    // queue depth, a power of two so the pointers wrap by themselves
    localparam int QDEPTH      = 4;
    localparam int QPTR_BITS   = $clog2(QDEPTH);

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_TRANSPARENT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_LINE_WIDTH  = 2'd1;

    localparam logic [CFG_BITS-1:0] LINE_WIDTH_RESET = 13'd64;

    localparam logic [1:0] HDR_NEWLINE = 2'd0;
    localparam logic [1:0] HDR_SKIP    = 2'd1;
    localparam logic [1:0] HDR_COPY    = 2'd2;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] data;
        logic                 is_word;
        logic                 ovf;
    } write_t;

    typedef struct packed {
        write_t [MAX_WRITES-1:0] wr;
        logic   [SLOT_BITS-1:0]  cnt_m1;
    } bundle_t;

    typedef struct packed {
        logic    valid;
        bundle_t bundle;
    } q_push_t;

    typedef struct packed {
        logic    valid;
        bundle_t bundle;
    } q_head_t;

    typedef struct packed {
        logic                    valid;
        logic [CFG_IDX_BITS-1:0] index;
        logic [CFG_BITS-1:0]     data;
    } cfg_wr_t;

    function automatic logic [DATA_BITS-1:0] header_word(
        input logic [1:0]          kind,
        input logic [LEN_BITS-1:0] len
    );
        return {14'd0, kind, len};
    endfunction

endpackage

[hw/rtl/tsre_front.sv]
module tsre_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tsre_pkg::cfg_wr_t             cfg,
    input  logic                          push,
    input  logic [tsre_pkg::PIXEL_BITS-1:0] pixel,
    input  logic                          frame_start,
    input  logic                          q_full,
    output tsre_pkg::q_push_t             q_push
);

    logic [tsre_pkg::PIXEL_BITS-1:0]  trans_color_reg;
    logic [tsre_pkg::CFG_BITS-1:0]    line_width_reg;

    logic [tsre_pkg::OFFSET_BITS-1:0] rec_off_reg, rec_off_next;
    logic [tsre_pkg::OFFSET_BITS-1:0] byte_off_reg, byte_off_next;
    logic [tsre_pkg::OFFSET_BITS-1:0] line_hdr_reg, line_hdr_next;
    logic                             in_copy_reg, in_copy_next;
    logic [tsre_pkg::COL_BITS-1:0]    run_cnt_reg, run_cnt_next;
    logic [tsre_pkg::LEN_BITS-1:0]    line_bytes_reg, line_bytes_next;
    logic [tsre_pkg::COL_BITS-1:0]    column_reg, column_next;
    logic                             wrapped_reg, wrapped_next;

    logic                             accept;
    logic                             transparent;
    logic [tsre_pkg::COL_BITS-1:0]    eff_width;
    tsre_pkg::write_t [tsre_pkg::MAX_WRITES-1:0] wr;
    logic [tsre_pkg::WCNT_BITS-1:0]   n_wr;
    logic [tsre_pkg::OFFSET_BITS:0]   sum;

    function automatic logic [tsre_pkg::OFFSET_BITS:0] adv(
        input logic [tsre_pkg::OFFSET_BITS-1:0] off,
        input logic [3:0]                       inc
    );
        return {1'b0, off} + (tsre_pkg::OFFSET_BITS + 1)'(inc);
    endfunction

    assign accept      = push && !q_full;
    assign transparent = (pixel == trans_color_reg);

    always_comb
    begin
        if (line_width_reg == '0)
            eff_width = tsre_pkg::COL_BITS'(1);
        else if (tsre_pkg::COL_BITS'(line_width_reg) > tsre_pkg::COL_BITS'(tsre_pkg::MAX_WIDTH))
            eff_width = tsre_pkg::COL_BITS'(tsre_pkg::MAX_WIDTH);
        else
            eff_width = tsre_pkg::COL_BITS'(line_width_reg);
    end

    // Whole pixel step resolved here; writes are listed in issue order with
    // the wrap flag as it stands at each one.
    always_comb
    begin
        rec_off_next    = rec_off_reg;
        byte_off_next   = byte_off_reg;
        line_hdr_next   = line_hdr_reg;
        in_copy_next    = in_copy_reg;
        run_cnt_next    = run_cnt_reg;
        line_bytes_next = line_bytes_reg;
        column_next     = column_reg;
        wrapped_next    = wrapped_reg;
        wr              = '0;
        n_wr            = '0;
        sum             = '0;

        if (frame_start)
        begin
            rec_off_next    = '0;
            byte_off_next   = '0;
            line_hdr_next   = '0;
            in_copy_next    = 1'b0;
            run_cnt_next    = '0;
            line_bytes_next = '0;
            column_next     = '0;
            wrapped_next    = 1'b0;
        end

        if (column_next == '0)
        begin
            line_hdr_next = rec_off_next;
            sum = adv(rec_off_next, 4'd4);
            wrapped_next = wrapped_next | sum[tsre_pkg::OFFSET_BITS];
            rec_off_next = sum[tsre_pkg::OFFSET_BITS-1:0];
            sum = adv(rec_off_next, 4'd4);
            wrapped_next = wrapped_next | sum[tsre_pkg::OFFSET_BITS];
            byte_off_next = sum[tsre_pkg::OFFSET_BITS-1:0];
            run_cnt_next = tsre_pkg::COL_BITS'(1);
            if (transparent)
            begin
                in_copy_next    = 1'b0;
                line_bytes_next = tsre_pkg::LEN_BITS'(8);
            end
            else
            begin
                in_copy_next = 1'b1;
                wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].addr    = tsre_pkg::ADDR_BITS'(byte_off_next);
                wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].data    = tsre_pkg::DATA_BITS'(pixel);
                wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].is_word = 1'b0;
                wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].ovf     = wrapped_next;
                n_wr = n_wr + 1'b1;
                sum = adv(byte_off_next, 4'd1);
                wrapped_next = wrapped_next | sum[tsre_pkg::OFFSET_BITS];
                byte_off_next = sum[tsre_pkg::OFFSET_BITS-1:0];
                line_bytes_next = tsre_pkg::LEN_BITS'(9);
            end
        end
        else if (transparent)
        begin
            if (!in_copy_next)
            begin
                run_cnt_next = run_cnt_next + 1'b1;
            end
            else
            begin
                wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].addr    = tsre_pkg::ADDR_BITS'(rec_off_next);
                wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].data    = tsre_pkg::header_word(
                    tsre_pkg::HDR_COPY, tsre_pkg::LEN_BITS'(run_cnt_next));
                wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].is_word = 1'b1;
                wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].ovf     = wrapped_next;
                n_wr = n_wr + 1'b1;
                rec_off_next    = byte_off_next;
                in_copy_next    = 1'b0;
                run_cnt_next    = tsre_pkg::COL_BITS'(1);
                line_bytes_next = line_bytes_next + tsre_pkg::LEN_BITS'(4);
            end
        end
        else
        begin
            if (in_copy_next)
            begin
                run_cnt_next = run_cnt_next + 1'b1;
            end
            else
            begin
                // skip run ends: its header, then a fresh copy header slot
                wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].addr    = tsre_pkg::ADDR_BITS'(rec_off_next);
                wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].data    = tsre_pkg::header_word(
                    tsre_pkg::HDR_SKIP, tsre_pkg::LEN_BITS'(run_cnt_next));
                wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].is_word = 1'b1;
                wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].ovf     = wrapped_next;
                n_wr = n_wr + 1'b1;
                sum = adv(rec_off_next, 4'd4);
                wrapped_next = wrapped_next | sum[tsre_pkg::OFFSET_BITS];
                rec_off_next = sum[tsre_pkg::OFFSET_BITS-1:0];
                sum = adv(rec_off_next, 4'd4);
                wrapped_next = wrapped_next | sum[tsre_pkg::OFFSET_BITS];
                byte_off_next = sum[tsre_pkg::OFFSET_BITS-1:0];
                in_copy_next = 1'b1;
                run_cnt_next = tsre_pkg::COL_BITS'(1);
                line_bytes_next = line_bytes_next + tsre_pkg::LEN_BITS'(4);
            end
            wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].addr    = tsre_pkg::ADDR_BITS'(byte_off_next);
            wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].data    = tsre_pkg::DATA_BITS'(pixel);
            wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].is_word = 1'b0;
            wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].ovf     = wrapped_next;
            n_wr = n_wr + 1'b1;
            sum = adv(byte_off_next, 4'd1);
            wrapped_next = wrapped_next | sum[tsre_pkg::OFFSET_BITS];
            byte_off_next = sum[tsre_pkg::OFFSET_BITS-1:0];
            line_bytes_next = line_bytes_next + tsre_pkg::LEN_BITS'(1);
        end

        column_next = column_next + 1'b1;
        if (column_next >= eff_width)
        begin
            wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].addr    = tsre_pkg::ADDR_BITS'(rec_off_next);
            wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].data    = tsre_pkg::header_word(
                in_copy_next ? tsre_pkg::HDR_COPY : tsre_pkg::HDR_SKIP,
                tsre_pkg::LEN_BITS'(run_cnt_next));
            wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].is_word = 1'b1;
            wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].ovf     = wrapped_next;
            n_wr = n_wr + 1'b1;
            if (in_copy_next)
            begin
                rec_off_next = byte_off_next;
            end
            else
            begin
                sum = adv(rec_off_next, 4'd4);
                wrapped_next = wrapped_next | sum[tsre_pkg::OFFSET_BITS];
                rec_off_next = sum[tsre_pkg::OFFSET_BITS-1:0];
            end
            wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].addr    = tsre_pkg::ADDR_BITS'(line_hdr_next);
            wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].data    = tsre_pkg::header_word(
                tsre_pkg::HDR_NEWLINE, line_bytes_next);
            wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].is_word = 1'b1;
            wr[n_wr[tsre_pkg::SLOT_BITS-1:0]].ovf     = wrapped_next;
            n_wr = n_wr + 1'b1;
            column_next  = '0;
            in_copy_next = 1'b0;
            run_cnt_next = '0;
        end
    end

    // pixels that only extend a skip run put nothing in the queue
    always_comb
    begin
        q_push.valid         = accept && (n_wr != '0);
        q_push.bundle.wr     = wr;
        q_push.bundle.cnt_m1 = tsre_pkg::SLOT_BITS'(n_wr - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trans_color_reg <= '0;
            line_width_reg  <= tsre_pkg::LINE_WIDTH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                tsre_pkg::CFG_IDX_TRANSPARENT:
                    trans_color_reg <= cfg.data[tsre_pkg::PIXEL_BITS-1:0];
                tsre_pkg::CFG_IDX_LINE_WIDTH:
                    line_width_reg  <= cfg.data;
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_off_reg    <= '0;
            byte_off_reg   <= '0;
            line_hdr_reg   <= '0;
            in_copy_reg    <= 1'b0;
            run_cnt_reg    <= '0;
            line_bytes_reg <= '0;
            column_reg     <= '0;
            wrapped_reg    <= 1'b0;
        end
        else if (accept)
        begin
            rec_off_reg    <= rec_off_next;
            byte_off_reg   <= byte_off_next;
            line_hdr_reg   <= line_hdr_next;
            in_copy_reg    <= in_copy_next;
            run_cnt_reg    <= run_cnt_next;
            line_bytes_reg <= line_bytes_next;
            column_reg     <= column_next;
            wrapped_reg    <= wrapped_next;
        end
    end

endmodule

[hw/rtl/tsre_queue.sv]
module tsre_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  tsre_pkg::q_push_t q_push,
    output logic              q_full,
    output tsre_pkg::q_head_t q_head,
    input  logic              q_pop
);

    tsre_pkg::bundle_t                entry_reg [tsre_pkg::QDEPTH];
    logic [tsre_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [tsre_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [tsre_pkg::QPTR_BITS:0]     count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign q_full  = (count_reg == (tsre_pkg::QPTR_BITS + 1)'(tsre_pkg::QDEPTH));
    assign do_push = q_push.valid && !q_full;
    assign do_pop  = q_pop && (count_reg != '0);

    always_comb
    begin
        q_head.valid  = (count_reg != '0);
        q_head.bundle = entry_reg[rd_ptr_reg];
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= q_push.bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

[hw/rtl/tsre_back.sv]
module tsre_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tsre_pkg::q_head_t              q_head,
    output logic                           q_pop,
    output logic                           empty,
    input  logic                           pop,
    output logic [tsre_pkg::ADDR_BITS-1:0] write_addr,
    output logic [tsre_pkg::DATA_BITS-1:0] write_data,
    output logic                           is_word,
    output logic                           last,
    output logic                           overflow
);

    logic                           out_valid_reg;
    tsre_pkg::write_t               out_wr_reg;
    logic                           out_last_reg;
    logic [tsre_pkg::SLOT_BITS-1:0] slot_reg;
    logic                           load;
    logic                           slot_last;

    // output register refills whenever it is empty or being taken
    assign load      = !out_valid_reg || pop;
    assign slot_last = (slot_reg == q_head.bundle.cnt_m1);
    assign q_pop     = load && q_head.valid && slot_last;

    assign empty      = !out_valid_reg;
    assign write_addr = out_wr_reg.addr;
    assign write_data = out_wr_reg.data;
    assign is_word    = out_wr_reg.is_word;
    assign overflow   = out_wr_reg.ovf;
    assign last       = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (load && q_head.valid)
        begin
            out_wr_reg   <= q_head.bundle.wr[slot_reg];
            out_last_reg <= slot_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            slot_reg      <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= q_head.valid;
            if (q_head.valid)
                slot_reg <= slot_last ? '0 : slot_reg + 1'b1;
        end
    end

endmodule

[hw/rtl/transparent_sprite_rle_encoder_unit.sv]
// Path: the writes of a taken pixel are registered into the pixel queue and then into
//   the output register before the result ports; they leave one per cycle as popped.
// Throughput: one pixel per cycle while each pixel causes at most one write and results are
//   popped; a pixel causing k writes (up to 4) holds the single result port for k pops,
//   and the 4-entry pixel queue between classifier and write sequencer absorbs the burst.
// Reset: asynchronous, active low; queue and output empty, offsets and counters zero.
module transparent_sprite_rle_encoder_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tsre_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [tsre_pkg::CFG_BITS-1:0]     cfg_data,
    input  logic                              push,
    output logic                              full,
    input  logic [tsre_pkg::PIXEL_BITS-1:0]   pixel,
    input  logic                              frame_start,
    output logic                              empty,
    input  logic                              pop,
    output logic [tsre_pkg::ADDR_BITS-1:0]    write_addr,
    output logic [tsre_pkg::DATA_BITS-1:0]    write_data,
    output logic                              is_word,
    output logic                              last,
    output logic                              overflow
);

    tsre_pkg::cfg_wr_t cfg;
    tsre_pkg::q_push_t q_push;
    tsre_pkg::q_head_t q_head;
    logic              q_full;
    logic              q_pop;

    assign cfg_ready = 1'b1;
    assign full      = q_full;

    always_comb
    begin
        cfg.valid = cfg_valid;
        cfg.index = cfg_index;
        cfg.data  = cfg_data;
    end

    tsre_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .push        (push),
        .pixel       (pixel),
        .frame_start (frame_start),
        .q_full      (q_full),
        .q_push      (q_push)
    );

    tsre_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .q_head (q_head),
        .q_pop  (q_pop)
    );

    tsre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .empty      (empty),
        .pop        (pop),
        .write_addr (write_addr),
        .write_data (write_data),
        .is_word    (is_word),
        .last       (last),
        .overflow   (overflow)
    );

endmodule

[hw/rtl/tsre_checker.sv]
module tsre_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              empty,
    input logic                              pop,
    input logic [tsre_pkg::ADDR_BITS-1:0]    write_addr,
    input logic [tsre_pkg::DATA_BITS-1:0]    write_data,
    input logic                              is_word,
    input logic                              last,
    input logic                              overflow
);

    // a waiting item that is not taken stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(write_addr) && $stable(write_data)
                              && $stable(is_word) && $stable(last) && $stable(overflow)))
        else $error("stalled result changed");

    // byte writes carry only the pixel
    a_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !is_word) |-> (write_data[31:8] == 24'd0))
        else $error("byte write with upper data bits set");

    // header words: only type and length bits, type never 3
    a_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_word) |-> (write_data[31:18] == 14'd0 && write_data[17:16] != 2'd3))
        else $error("malformed header word");

    // the newline header always closes the pixel's writes
    a_nl_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_word && write_data[17:16] == tsre_pkg::HDR_NEWLINE) |-> last)
        else $error("newline header not marked last");

endmodule

bind transparent_sprite_rle_encoder_unit tsre_checker u_checker (.*);
